// ===== rtl/core/slwc_pkg.sv =====
// Shared types and constants for the sorted list with cursor.
package slwc_pkg;

	localparam int DATA_W = 32;
	localparam int CAPACITY_DEF = 64;
	localparam int REQ_W = 3;
	localparam int ERR_W = 2;

	localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RETREAT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_FIRST   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_LAST    = 3'd6;

	localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_POS  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_PAST = 2'd2;
	localparam logic [ERR_W-1:0] ERR_FULL = 2'd3;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_op_t;

endpackage

// ===== rtl/core/sorted_list_with_cursor.sv =====
// Top level of the sorted list with cursor: request control, cursor and count, and the cell row.
// A request is taken when start is high and busy is low. It executes in the following cycle,
// with busy high, and its result appears on the result ports for one cycle with done high in
// the cycle after that; a new request can be taken in that same cycle. The execute cycle
// updates the cell row, and the result cycle reads the element at the cursor. The receiver
// cannot stall results, and no clearing pass follows reset.
module sorted_list_with_cursor #(
	parameter int CAPACITY = slwc_pkg::CAPACITY_DEF,
	localparam int CNT_W = $clog2(CAPACITY + 2),
	localparam int CNTO_W = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [slwc_pkg::REQ_W-1:0]          req_type,
	input  logic signed [slwc_pkg::DATA_W-1:0]  new_value,
	input  logic                                cfg_wr_en,
	input  logic signed [slwc_pkg::DATA_W-1:0]  cfg_wr_data,
	output logic                                done,
	output logic signed [slwc_pkg::DATA_W-1:0]  cursor_value,
	output logic                                at_start,
	output logic                                at_end,
	output logic                                is_empty,
	output logic [CNTO_W-1:0]                   entry_count,
	output logic [slwc_pkg::ERR_W-1:0]          error_code
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_EXEC   = 2'd1;
	localparam logic [1:0] PH_RESULT = 2'd2;

	logic [1:0]                          phase_q;
	logic [slwc_pkg::REQ_W-1:0]          req_q;
	logic signed [slwc_pkg::DATA_W-1:0]  nv_q;
	logic signed [slwc_pkg::DATA_W-1:0]  undef_q;
	logic [CNT_W-1:0]                    count_q;
	logic [CNT_W-1:0]                    cursor_q;
	logic [slwc_pkg::ERR_W-1:0]          err_q;

	logic                                accept;
	logic                                exec;
	logic                                on_el;
	logic [CNT_W-1:0]                    tail_pos;
	logic                                hit_le;
	logic signed [slwc_pkg::DATA_W-1:0]  rd_value;
	logic [CNT_W-1:0]                    nxt_count;
	logic [CNT_W-1:0]                    nxt_cursor;
	logic [slwc_pkg::ERR_W-1:0]          nxt_err;
	slwc_pkg::cell_op_t                  op;

	logic signed [slwc_pkg::DATA_W-1:0]  entry_w [CAPACITY];
	logic [CAPACITY-1:0]                 le_w;
	logic [CAPACITY-1:0]                 hit_w;

	assign busy     = phase_q == PH_EXEC;
	assign done     = phase_q == PH_RESULT;
	assign accept   = start && !busy;
	assign exec     = phase_q == PH_EXEC;
	assign tail_pos = CNT_W'(count_q + 1'b1);
	assign on_el    = (cursor_q != '0) && (cursor_q <= count_q);
	assign hit_le   = |(hit_w & le_w);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [slwc_pkg::DATA_W-1:0] left_e;
		logic signed [slwc_pkg::DATA_W-1:0] right_e;
		logic                               left_l;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_e = entry_w[i-1];
			assign left_l = le_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = entry_w[i+1];
		end

		slwc_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.op          (op),
			.count       (count_q),
			.cursor      (cursor_q),
			.new_value   (nv_q),
			.left_entry  (left_e),
			.left_le     (left_l),
			.right_entry (right_e),
			.entry       (entry_w[i]),
			.le          (le_w[i]),
			.hit         (hit_w[i])
		);
	end

	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_w[i]) begin
				rd_value = rd_value | entry_w[i];
			end
		end
	end

	always_comb begin
		nxt_count  = count_q;
		nxt_cursor = cursor_q;
		nxt_err    = slwc_pkg::ERR_OK;
		op         = '0;
		case (req_q)
			slwc_pkg::REQ_INSERT: begin
				if (count_q >= CNT_W'(CAPACITY)) begin
					nxt_err = slwc_pkg::ERR_FULL;
				end else begin
					op.ins    = exec;
					nxt_count = CNT_W'(count_q + 1'b1);
					if ((cursor_q != '0) && !hit_le) begin
						nxt_cursor = CNT_W'(cursor_q + 1'b1);
					end
				end
			end
			slwc_pkg::REQ_DELETE: begin
				if (!on_el) begin
					nxt_err = slwc_pkg::ERR_POS;
				end else begin
					op.del    = exec;
					nxt_count = CNT_W'(count_q - 1'b1);
				end
			end
			slwc_pkg::REQ_ADVANCE: begin
				if (cursor_q >= tail_pos) begin
					nxt_err = slwc_pkg::ERR_PAST;
				end else begin
					nxt_cursor = CNT_W'(cursor_q + 1'b1);
				end
			end
			slwc_pkg::REQ_RETREAT: begin
				if (cursor_q == '0) begin
					nxt_err = slwc_pkg::ERR_PAST;
				end else begin
					nxt_cursor = CNT_W'(cursor_q - 1'b1);
				end
			end
			slwc_pkg::REQ_FIRST: begin
				nxt_cursor = CNT_W'(1);
			end
			slwc_pkg::REQ_LAST: begin
				nxt_cursor = count_q;
			end
			default: begin
				if (!on_el) begin
					nxt_err = slwc_pkg::ERR_POS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			cursor_q <= CNT_W'(1);
			undef_q  <= '0;
			err_q    <= slwc_pkg::ERR_OK;
		end else begin
			if (cfg_wr_en) begin
				undef_q <= cfg_wr_data;
			end
			if (accept) begin
				phase_q <= PH_EXEC;
			end else if (exec) begin
				phase_q <= PH_RESULT;
			end else begin
				phase_q <= PH_IDLE;
			end
			if (exec) begin
				count_q  <= nxt_count;
				cursor_q <= nxt_cursor;
				err_q    <= nxt_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			nv_q  <= new_value;
		end
	end

	assign cursor_value = on_el ? rd_value : undef_q;
	assign at_start     = cursor_q == '0;
	assign at_end       = cursor_q == tail_pos;
	assign is_empty     = count_q == '0;
	assign entry_count  = CNTO_W'(count_q);
	assign error_code   = err_q;

	// The list never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	// The cursor never goes beyond the tail position.
	assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= tail_pos)
		else $error("cursor beyond tail position");

	// Every executed request yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> done)
		else $error("missing result after execution");

	// List state only changes in an execute cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(count_q) && $stable(cursor_q))
		else $error("list state changed outside execution");

endmodule

// ===== rtl/core/slwc_cell.sv =====
// One storage cell of the sorted list: holds one element and shifts with its neighbors.
module slwc_cell #(
	parameter int IDX = 0,
	parameter int CNT_W = 7
) (
	input  logic                            clk,
	input  slwc_pkg::cell_op_t              op,
	input  logic [CNT_W-1:0]                count,
	input  logic [CNT_W-1:0]                cursor,
	input  logic signed [slwc_pkg::DATA_W-1:0] new_value,
	input  logic signed [slwc_pkg::DATA_W-1:0] left_entry,
	input  logic                            left_le,
	input  logic signed [slwc_pkg::DATA_W-1:0] right_entry,
	output logic signed [slwc_pkg::DATA_W-1:0] entry,
	output logic                            le,
	output logic                            hit
);

	logic signed [slwc_pkg::DATA_W-1:0] entry_q;
	logic                               occ;
	logic                               del_here;

	assign occ      = CNT_W'(IDX) < count;
	assign le       = occ && (entry_q <= new_value);
	assign hit      = cursor == CNT_W'(IDX + 1);
	assign del_here = cursor <= CNT_W'(IDX + 1);
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (op.ins && !le) begin
			entry_q <= left_le ? new_value : left_entry;
		end else if (op.del && del_here) begin
			entry_q <= right_entry;
		end
	end

endmodule
